/* hdl/rml_pkg.sv */
// Shared types and constants of the resource map lookup block.
// No dependencies; compile first.
package rml_pkg;

   // Image store geometry
   localparam int unsigned IMAGE_BYTES = 65536;
   localparam int unsigned MEM_AW      = $clog2(IMAGE_BYTES);
   localparam int unsigned SIZE_W      = MEM_AW + 1;

   // Byte count of one fetch
   localparam int unsigned NB_W = 3;
   localparam logic [NB_W-1:0] WORD_BYTES = NB_W'(4);
   localparam logic [NB_W-1:0] OFFS_BYTES = NB_W'(3);
   localparam logic [NB_W-1:0] HALF_BYTES = NB_W'(2);

   // Resource file layout
   localparam int unsigned HEADER_BYTES  = 16;
   localparam int unsigned MAP_MIN_BYTES = 30;
   localparam logic [MEM_AW-1:0] HDR_DATA_OFF_AT = MEM_AW'(0);
   localparam logic [MEM_AW-1:0] HDR_MAP_OFF_AT  = MEM_AW'(4);
   localparam logic [MEM_AW-1:0] MAP_TYPELIST_AT = MEM_AW'(24);
   localparam logic [MEM_AW-1:0] TYPE_LIST_HDR   = MEM_AW'(2);
   localparam logic [MEM_AW-1:0] TYPE_ENTRY_BYTES = MEM_AW'(8);
   localparam logic [MEM_AW-1:0] TYPE_COUNT_AT   = MEM_AW'(4);
   localparam logic [MEM_AW-1:0] TYPE_REFS_AT    = MEM_AW'(6);
   localparam logic [MEM_AW-1:0] REF_ENTRY_BYTES = MEM_AW'(12);
   localparam logic [MEM_AW-1:0] REF_DATA_AT     = MEM_AW'(5);
   localparam logic [MEM_AW-1:0] LEN_WORD_BYTES  = MEM_AW'(4);

   // Item codes
   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      STS_FOUND     = 2'd0,
      STS_BAD_IMAGE = 2'd1,
      STS_NO_TYPE   = 2'd2,
      STS_NO_ID     = 2'd3
   } rml_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_HDR_DATA,
      S_HDR_MAP,
      S_TL_OFF,
      S_TL_CNT,
      S_TYPE_NEXT,
      S_TYPE_CODE,
      S_REF_CNT,
      S_REF_OFF,
      S_REF_NEXT,
      S_REF_ID,
      S_REF_DATA,
      S_DATA_LEN,
      S_RESP
   } rml_state_type;

   // Sequencer to fetch unit
   typedef struct packed {
      logic              start;
      logic [MEM_AW-1:0] addr;
      logic [NB_W-1:0]   nbytes;
   } rml_fetch_cmd_type;

   // Fetch unit to sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } rml_fetch_sts_type;

   // Image byte write
   typedef struct packed {
      logic              we;
      logic [MEM_AW-1:0] addr;
      logic [7:0]        data;
   } rml_wr_type;

endpackage

/* hdl/rml_if.sv */
// Channel interfaces of the resource map lookup block: request, response, register write.
// Depends on rml_pkg.
interface rml_req_if import rml_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                action;
   logic [MEM_AW-1:0]   load_address;
   logic [7:0]          load_byte;
   logic [31:0]         res_type;
   logic signed [15:0]  res_id;

   modport source (output valid, action, load_address, load_byte, res_type, res_id,
                   input ready);
   modport sink   (input valid, action, load_address, load_byte, res_type, res_id,
                   output ready);
endinterface

interface rml_rsp_if import rml_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [MEM_AW-1:0] data_address;
   logic [31:0]       data_length;

   modport source (output valid, status, data_address, data_length, input ready);
   modport sink   (input valid, status, data_address, data_length, output ready);
endinterface

interface rml_csr_if import rml_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] image_size;

   modport source (output valid, image_size, input ready);
   modport sink   (input valid, image_size, output ready);
endinterface

/* hdl/rml_fetch.sv */
// Image byte store and multi-byte big-endian fetch unit.
// Depends on rml_pkg.
module rml_fetch import rml_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  rml_wr_type        wr,
   input  rml_fetch_cmd_type cmd,
   output rml_fetch_sts_type sts,
   output logic [31:0]       word
);

   logic [7:0]        image_mem [IMAGE_BYTES];
   logic [7:0]        q_ff;
   logic              busy_ff, busy_in;
   logic              rdv_ff, rdv_in;
   logic              done_ff, done_in;
   logic [NB_W-1:0]   left_ff, left_in;
   logic [MEM_AW-1:0] addr_ff, addr_in;
   logic [31:0]       acc_ff, acc_in;
   logic              issue;

   // Write port for loads, registered read port for fetches
   always_ff @(posedge clock) begin
      if (wr.we) begin
         image_mem[wr.addr] <= wr.data;
      end
      q_ff <= image_mem[addr_ff];
   end

   assign issue = busy_ff && (left_ff != '0);

   always_comb begin
      busy_in = busy_ff;
      left_in = left_ff;
      addr_in = addr_ff;
      acc_in  = acc_ff;
      rdv_in  = issue;
      done_in = 1'b0;
      if (cmd.start) begin
         busy_in = 1'b1;
         left_in = cmd.nbytes;
         addr_in = cmd.addr;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (issue) begin
            addr_in = addr_ff + MEM_AW'(1);
            left_in = left_ff - NB_W'(1);
         end
         if (rdv_ff) begin
            acc_in = {acc_ff[23:0], q_ff};
         end
         // last byte arrives: finish
         if (!issue && rdv_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rdv_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rdv_ff  <= rdv_in;
         done_ff <= done_in;
      end
      left_ff <= left_in;
      addr_ff <= addr_in;
      acc_ff  <= acc_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign word     = acc_ff;

endmodule

/* hdl/resource_map_lookup.sv */
// Resource map lookup engine: holds a resource-file image loaded one byte per load transfer
// and walks its header, map, type list and reference list for each lookup transfer. A load
// gives no response. A lookup gives one response; every field is read byte by byte through
// the single read port of the image store. Short images answer straight from idle, bad maps
// after the two header reads. The image store is not cleared at reset; bytes must be loaded
// before a lookup reads them. All image addresses wrap at the store size. Write image_size
// only while no lookup is in flight.
// Depends on rml_pkg, rml_if and rml_fetch.
module resource_map_lookup import rml_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   rml_req_if.sink    req_ch,
   rml_rsp_if.source  rsp_ch,
   rml_csr_if.sink    csr_wr
);

   rml_state_type     state_ff, state_in;
   rml_status_type    status_ff, status_in;
   logic [SIZE_W-1:0] image_size_ff;

   // lookup key
   logic [31:0]       want_type_ff, want_type_in;
   logic [15:0]       want_id_ff, want_id_in;

   // walk pointers and counters
   logic [MEM_AW-1:0] data_off_ff, data_off_in;
   logic [MEM_AW-1:0] map_ff, map_in;
   logic [MEM_AW-1:0] tl_ff, tl_in;
   logic [MEM_AW-1:0] entry_ff, entry_in;
   logic [MEM_AW-1:0] ref_ff, ref_in;
   logic [MEM_AW-1:0] data_ff, data_in;
   logic [15:0]       count_ff, count_in;

   // result
   logic [MEM_AW-1:0] rsp_addr_ff, rsp_addr_in;
   logic [31:0]       rsp_len_ff, rsp_len_in;

   // shared address adder
   logic [MEM_AW-1:0] add_a, add_b, sum;

   rml_fetch_cmd_type fu_cmd;
   rml_fetch_sts_type fu_sts;
   rml_wr_type        wr;
   logic [31:0]       word;

   logic req_fire, lookup_fire, fetch_state, done;
   logic short_image, map_ok, type_hit, id_hit, count_zero;

   rml_fetch u_fetch (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .cmd   (fu_cmd),
      .sts   (fu_sts),
      .word  (word)
   );

   assign req_fire    = req_ch.valid && req_ch.ready;
   assign lookup_fire = req_fire && (req_ch.action == ACT_LOOKUP);
   assign done        = fu_sts.done;

   // Loads go straight to the store while idle
   assign wr.we   = req_fire && (req_ch.action == ACT_LOAD);
   assign wr.addr = req_ch.load_address;
   assign wr.data = req_ch.load_byte;

   assign short_image = image_size_ff < SIZE_W'(HEADER_BYTES);
   // map offset plus minimum map length, without wrap
   assign map_ok      = ({1'b0, word} + 33'(MAP_MIN_BYTES)) <= 33'(image_size_ff);
   assign type_hit    = word == want_type_ff;
   assign id_hit      = word[15:0] == want_id_ff;
   assign count_zero  = count_ff == '0;
   assign sum         = add_a + add_b;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (lookup_fire) begin
               state_in = short_image ? S_RESP : S_HDR_DATA;
            end
         end
         S_HDR_DATA: if (done) state_in = S_HDR_MAP;
         S_HDR_MAP: begin
            if (done) begin
               state_in = map_ok ? S_TL_OFF : S_RESP;
            end
         end
         S_TL_OFF:    if (done) state_in = S_TL_CNT;
         S_TL_CNT:    if (done) state_in = S_TYPE_NEXT;
         S_TYPE_NEXT: state_in = count_zero ? S_RESP : S_TYPE_CODE;
         S_TYPE_CODE: begin
            if (done) begin
               state_in = type_hit ? S_REF_CNT : S_TYPE_NEXT;
            end
         end
         S_REF_CNT:   if (done) state_in = S_REF_OFF;
         S_REF_OFF:   if (done) state_in = S_REF_NEXT;
         S_REF_NEXT:  state_in = count_zero ? S_RESP : S_REF_ID;
         S_REF_ID: begin
            if (done) begin
               state_in = id_hit ? S_REF_DATA : S_REF_NEXT;
            end
         end
         S_REF_DATA:  if (done) state_in = S_DATA_LEN;
         S_DATA_LEN:  if (done) state_in = S_RESP;
         S_RESP:      if (rsp_ch.ready) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // Outputs: handshakes, fetch commands and adder operands
   always_comb begin
      req_ch.ready  = state_ff == S_IDLE;
      rsp_ch.valid  = state_ff == S_RESP;
      fetch_state   = 1'b1;
      fu_cmd.addr   = '0;
      fu_cmd.nbytes = WORD_BYTES;
      add_a         = '0;
      add_b         = '0;
      unique case (state_ff)
         S_HDR_DATA: fu_cmd.addr = HDR_DATA_OFF_AT;
         S_HDR_MAP:  fu_cmd.addr = HDR_MAP_OFF_AT;
         S_TL_OFF: begin
            fu_cmd.nbytes = HALF_BYTES;
            fu_cmd.addr   = sum;
            add_a         = map_ff;
            add_b         = done ? word[MEM_AW-1:0] : MAP_TYPELIST_AT;
         end
         S_TL_CNT: begin
            fu_cmd.nbytes = HALF_BYTES;
            fu_cmd.addr   = tl_ff;
            add_a         = tl_ff;
            add_b         = TYPE_LIST_HDR;
         end
         S_TYPE_CODE: begin
            fu_cmd.addr = entry_ff;
            add_a       = entry_ff;
            add_b       = TYPE_ENTRY_BYTES;
         end
         S_REF_CNT: begin
            fu_cmd.nbytes = HALF_BYTES;
            fu_cmd.addr   = sum;
            add_a         = entry_ff;
            add_b         = TYPE_COUNT_AT;
         end
         S_REF_OFF: begin
            fu_cmd.nbytes = HALF_BYTES;
            fu_cmd.addr   = sum;
            add_a         = done ? tl_ff : entry_ff;
            add_b         = done ? word[MEM_AW-1:0] : TYPE_REFS_AT;
         end
         S_REF_ID: begin
            fu_cmd.nbytes = HALF_BYTES;
            fu_cmd.addr   = ref_ff;
            add_a         = ref_ff;
            add_b         = REF_ENTRY_BYTES;
         end
         S_REF_DATA: begin
            fu_cmd.nbytes = OFFS_BYTES;
            fu_cmd.addr   = sum;
            add_a         = done ? data_off_ff : ref_ff;
            add_b         = done ? word[MEM_AW-1:0] : REF_DATA_AT;
         end
         S_DATA_LEN: begin
            fu_cmd.addr = data_ff;
            add_a       = data_ff;
            add_b       = LEN_WORD_BYTES;
         end
         S_IDLE, S_TYPE_NEXT, S_REF_NEXT, S_RESP: fetch_state = 1'b0;
         default: fetch_state = 1'b0;
      endcase
      // launch once per fetch state, on entry
      fu_cmd.start = fetch_state && !fu_sts.busy && !done;
   end

   // Datapath updates
   always_comb begin
      status_in    = status_ff;
      want_type_in = want_type_ff;
      want_id_in   = want_id_ff;
      data_off_in  = data_off_ff;
      map_in       = map_ff;
      tl_in        = tl_ff;
      entry_in     = entry_ff;
      ref_in       = ref_ff;
      data_in      = data_ff;
      count_in     = count_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_len_in   = rsp_len_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (lookup_fire) begin
               want_type_in = req_ch.res_type;
               want_id_in   = req_ch.res_id;
               status_in    = STS_BAD_IMAGE;
               rsp_addr_in  = '0;
               rsp_len_in   = '0;
            end
         end
         S_HDR_DATA: if (done) data_off_in = word[MEM_AW-1:0];
         S_HDR_MAP: begin
            if (done) begin
               map_in = word[MEM_AW-1:0];
               if (map_ok) status_in = STS_NO_TYPE;
            end
         end
         S_TL_OFF: if (done) tl_in = sum;
         S_TL_CNT: begin
            if (done) begin
               // stored count is entries minus one; all ones means empty
               count_in = word[15:0] + 16'd1;
               entry_in = sum;
            end
         end
         S_TYPE_CODE: begin
            if (done) begin
               if (type_hit) begin
                  status_in = STS_NO_ID;
               end else begin
                  entry_in = sum;
                  count_in = count_ff - 16'd1;
               end
            end
         end
         S_REF_CNT: if (done) count_in = word[15:0] + 16'd1;
         S_REF_OFF: if (done) ref_in = sum;
         S_REF_ID: begin
            if (done && !id_hit) begin
               ref_in   = sum;
               count_in = count_ff - 16'd1;
            end
         end
         S_REF_DATA: if (done) data_in = sum;
         S_DATA_LEN: begin
            if (done) begin
               rsp_len_in  = word;
               rsp_addr_in = sum;
               status_in   = STS_FOUND;
            end
         end
         S_TYPE_NEXT, S_REF_NEXT, S_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         image_size_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr.valid && csr_wr.ready) begin
            image_size_ff <= csr_wr.image_size;
         end
      end
      status_ff    <= status_in;
      want_type_ff <= want_type_in;
      want_id_ff   <= want_id_in;
      data_off_ff  <= data_off_in;
      map_ff       <= map_in;
      tl_ff        <= tl_in;
      entry_ff     <= entry_in;
      ref_ff       <= ref_in;
      data_ff      <= data_in;
      count_ff     <= count_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_len_ff   <= rsp_len_in;
   end

   // Hold the register port open; writes must arrive only while idle, which the block does not enforce
   assign csr_wr.ready = 1'b1;

   assign rsp_ch.status       = status_ff;
   assign rsp_ch.data_address = rsp_addr_ff;
   assign rsp_ch.data_length  = rsp_len_ff;

   // No new transfer taken while the fetch unit is working
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      fu_sts.busy |-> !req_ch.ready)
      else $error("request taken during a fetch");

   // A miss carries zero address and length
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != STS_FOUND) |->
         (rsp_ch.data_address == '0 && rsp_ch.data_length == '0))
      else $error("miss response with non-zero fields");

   // Completion only follows a busy fetch
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      fu_sts.done |-> $past(fu_sts.busy))
      else $error("fetch completion without a fetch");

   // A fetch launch always leaves the fetch unit busy
   a_start_idle_unit: assert property (@(posedge clock) disable iff (reset)
      fu_cmd.start |=> fu_sts.busy)
      else $error("fetch launch lost");

endmodule

/* verif/tb_resource_map_lookup.sv */
// Self-checking testbench for resource_map_lookup: builds resource-file images, loads them
// byte by byte and checks every lookup response against an in-bench walk of the same image.
// Depends on rml_pkg, rml_if (rml_req_if, rml_rsp_if, rml_csr_if) and the block's RTL.
`timescale 1ns / 100ps

module tb_resource_map_lookup;
   import rml_pkg::*;

   localparam int unsigned ITEM_GOAL    = 950;
   localparam int unsigned STALL_LIMIT  = 3000;  // cycles without any transfer
   localparam int unsigned DRAIN_CYCLES = 64;
   localparam int unsigned LOAD_SETTLE  = 16;    // let a trailing load finish before a CSR write
   localparam int unsigned PRINT_LIMIT  = 40;
   localparam logic [SIZE_W-1:0] SIZE_MAX = '1;
   localparam longint unsigned MAP_OFF_MAX = 64'(SIZE_MAX) - MAP_MIN_BYTES;

   typedef struct {
      rml_status_type    status;
      logic [MEM_AW-1:0] data_address;
      logic [31:0]       data_length;
   } lookup_answer_type;

   typedef struct {
      logic              action;
      logic [MEM_AW-1:0] load_address;
      logic [7:0]        load_byte;
      logic [31:0]       res_type;
      logic [15:0]       res_id;
   } request_item_type;

   typedef struct {
      logic [31:0] res_type;
      logic [15:0] res_id;
   } resource_key_type;

   // Holds the answers still owed by the block, oldest first.
   class answer_ledger;
      lookup_answer_type pending_answers[$];
      int unsigned       errors;

      function new();
         errors = 0;
      endfunction

      function void note_lookup(lookup_answer_type ans);
         pending_answers.push_back(ans);
      endfunction

      function int unsigned outstanding();
         return pending_answers.size();
      endfunction

      task report(string msg);
         if (errors < PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $time, msg);
         errors++;
      endtask

      task check_answer(logic [1:0] status_seen, logic [MEM_AW-1:0] addr_seen,
                        logic [31:0] len_seen);
         lookup_answer_type want;
         if (pending_answers.size() == 0) begin
            report("response transfer with no lookup outstanding");
            return;
         end
         want = pending_answers.pop_front();
         if (status_seen !== want.status)
            report($sformatf("status %0d, expected %0d", status_seen, want.status));
         if (addr_seen !== want.data_address)
            report($sformatf("data_address %h, expected %h", addr_seen, want.data_address));
         if (len_seen !== want.data_length)
            report($sformatf("data_length %h, expected %h", len_seen, want.data_length));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   rml_req_if req_ch();
   rml_rsp_if rsp_ch();
   rml_csr_if csr_wr();

   resource_map_lookup dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_wr (csr_wr)
   );

   answer_ledger ledger;

   // Bench copy of the image store, and which bytes the block has really been given
   bit [7:0] image_copy [IMAGE_BYTES];
   bit       loaded     [IMAGE_BYTES];
   logic [SIZE_W-1:0] size_copy = '0;

   // Intended layout of the current image; bytes are loaded on demand as lookups need them
   bit [7:0]    plan_val [IMAGE_BYTES];
   bit          plan_set [IMAGE_BYTES];
   int unsigned planned_addrs[$];
   logic [63:0] plan_map_off;
   resource_key_type known_keys[$];
   logic [31:0]      known_types[$];

   int          first_gap;         // first byte the walk needed but the block lacks, or -1
   int unsigned items_sent = 0;
   bit          idling = 1'b1;
   int unsigned quiet_cycles = 0;

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Image walk
   // ---------------------------------------------------------------------------------------

   // Big-endian fetch of n bytes with wrap at the store size. Flag the first byte that is
   // either missing from the block or stale against the current layout.
   function automatic logic [31:0] fetch_be(logic [63:0] at, int unsigned n);
      logic [31:0]       v;
      logic [MEM_AW-1:0] a;
      int unsigned       k;
      v = '0;
      for (k = 0; k < n; k++) begin
         a = MEM_AW'(at + k);
         if (first_gap < 0 && (!loaded[a] || (plan_set[a] && image_copy[a] != plan_val[a])))
            first_gap = int'(a);
         v = (v << 8) | image_copy[a];
      end
      return v;
   endfunction

   // Header, map, type list, reference list, length word. Only the first type entry with a
   // matching code is searched; a count field of all ones means an empty list.
   function automatic lookup_answer_type walk_resource_map(logic [31:0] want_type,
                                                           logic [15:0] want_id);
      lookup_answer_type ans;
      logic [63:0]       data_off, map_off, type_list, entry, ref_at, data_at;
      int unsigned       type_count, ref_count, i, j;
      ans.status       = STS_BAD_IMAGE;
      ans.data_address = '0;
      ans.data_length  = '0;
      first_gap        = -1;
      if (size_copy >= HEADER_BYTES) begin
         data_off = 64'(fetch_be(HDR_DATA_OFF_AT, 4));
         map_off  = 64'(fetch_be(HDR_MAP_OFF_AT, 4));
         // the bad-map check is done without wrap, against image_size as written
         if (map_off + MAP_MIN_BYTES <= 64'(size_copy)) begin
            type_list  = map_off + fetch_be(map_off + MAP_TYPELIST_AT, 2);
            type_count = (fetch_be(type_list, 2) + 1) & 32'hFFFF;
            entry      = type_list + TYPE_LIST_HDR;
            ans.status = STS_NO_TYPE;
            for (i = 0; i < type_count && first_gap < 0; i++) begin
               if (fetch_be(entry, 4) == want_type) begin
                  ref_count  = (fetch_be(entry + TYPE_COUNT_AT, 2) + 1) & 32'hFFFF;
                  ref_at     = type_list + fetch_be(entry + TYPE_REFS_AT, 2);
                  ans.status = STS_NO_ID;
                  for (j = 0; j < ref_count && first_gap < 0; j++) begin
                     if (fetch_be(ref_at, 2) == want_id) begin
                        data_at              = data_off + fetch_be(ref_at + REF_DATA_AT, 3);
                        ans.data_length      = fetch_be(data_at, 4);
                        ans.data_address     = MEM_AW'(data_at + LEN_WORD_BYTES);
                        ans.status           = STS_FOUND;
                        break;
                     end
                     ref_at += REF_ENTRY_BYTES;
                  end
                  break;
               end
               entry += TYPE_ENTRY_BYTES;
            end
         end
      end
      return ans;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Image layout planning
   // ---------------------------------------------------------------------------------------

   function automatic bit region_free(logic [63:0] at, int unsigned n);
      int unsigned k;
      for (k = 0; k < n; k++)
         if (plan_set[MEM_AW'(at + k)])
            return 1'b0;
      return 1'b1;
   endfunction

   function automatic void plan_bytes(logic [63:0] at, int unsigned n, logic [31:0] v);
      logic [MEM_AW-1:0] a;
      int unsigned       k;
      for (k = 0; k < n; k++) begin
         a = MEM_AW'(at + k);
         plan_val[a] = 8'(v >> (8 * (n - 1 - k)));
         if (!plan_set[a])
            planned_addrs.push_back(a);
         plan_set[a] = 1'b1;
      end
   endfunction

   // Lay out a fresh image: header at zero, map anywhere (possibly beyond the store, so it
   // wraps), type list and reference lists at random relative offsets, length words after
   // a random data offset. Regions never overlap. With dup_type the second type entry
   // repeats the first code, so its references are shadowed by the first entry.
   function automatic void plan_image(int unsigned n_types, int unsigned min_refs,
                                      int unsigned max_refs, bit dup_type, bit extremes,
                                      bit top_map);
      logic [63:0] map_off, type_list, entry, ref_base, ref_at;
      logic [31:0] data_off, code;
      logic [15:0] tl_rel, ref_rel, rid;
      logic [23:0] data_rel;
      int unsigned n_refs, tries, t, r;
      foreach (planned_addrs[k])
         plan_set[planned_addrs[k]] = 1'b0;
      planned_addrs.delete();
      known_keys.delete();
      known_types.delete();

      data_off = extremes ? 32'hFFFF_FFFF : $urandom();
      plan_bytes(HDR_DATA_OFF_AT, 4, data_off);
      plan_bytes(HDR_MAP_OFF_AT, 4, 32'h0);
      if (top_map)
         map_off = MAP_OFF_MAX;
      else begin
         do begin
            map_off = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAP_OFF_MAX)
                                                   : $urandom_range(0, IMAGE_BYTES - 1);
         end while (!region_free(map_off + MAP_TYPELIST_AT, 2));
      end
      plan_map_off = map_off;
      plan_bytes(HDR_MAP_OFF_AT, 4, 32'(map_off));
      plan_bytes(map_off + MAP_TYPELIST_AT, 2, 32'h0);

      tries = 0;
      do begin
         tl_rel = (extremes && tries == 0) ? 16'hFFFF : 16'($urandom());
         tries++;
      end while (!region_free(map_off + tl_rel, TYPE_LIST_HDR + TYPE_ENTRY_BYTES * n_types));
      plan_bytes(map_off + MAP_TYPELIST_AT, 2, tl_rel);
      type_list = map_off + tl_rel;
      plan_bytes(type_list, 2, 32'(16'(n_types - 1)));
      // reserve every entry before placing reference lists
      for (t = 0; t < n_types; t++)
         plan_bytes(type_list + TYPE_LIST_HDR + TYPE_ENTRY_BYTES * t, 8, 32'h0);

      for (t = 0; t < n_types; t++) begin
         code = (dup_type && t == 1) ? known_types[0] : $urandom();
         known_types.push_back(code);
         n_refs = $urandom_range(min_refs, max_refs);
         entry  = type_list + TYPE_LIST_HDR + TYPE_ENTRY_BYTES * t;
         plan_bytes(entry, 4, code);
         plan_bytes(entry + TYPE_COUNT_AT, 2, 32'(16'(n_refs - 1)));
         tries = 0;
         do begin
            ref_rel = (extremes && tries == 0) ? 16'hFFFF : 16'($urandom());
            tries++;
         end while (!region_free(type_list + ref_rel, REF_ENTRY_BYTES * n_refs));
         plan_bytes(entry + TYPE_REFS_AT, 2, ref_rel);
         ref_base = type_list + ref_rel;
         for (r = 0; r < 3 * n_refs; r++)
            plan_bytes(ref_base + 4 * r, 4, 32'h0);

         for (r = 0; r < n_refs; r++) begin
            ref_at = ref_base + REF_ENTRY_BYTES * r;
            rid    = 16'($urandom());
            plan_bytes(ref_at, 2, rid);
            tries = 0;
            do begin
               data_rel = (extremes && tries == 0) ? 24'hFF_FFFF : 24'($urandom());
               tries++;
            end while (!region_free(64'(data_off) + data_rel, 4));
            plan_bytes(ref_at + REF_DATA_AT, 3, data_rel);
            plan_bytes(64'(data_off) + data_rel, 4, $urandom());
            known_keys.push_back('{res_type: code, res_id: rid});
         end
      end
   endfunction

   // Mostly keys that exist, then present types with a stray ID, unknown types and the
   // field extremes.
   function automatic resource_key_type choose_key();
      resource_key_type key;
      int unsigned      sel;
      sel          = $urandom_range(0, 9);
      key.res_type = $urandom();
      key.res_id   = 16'($urandom());
      if (sel <= 5 && known_keys.size() != 0)
         key = known_keys[$urandom_range(0, known_keys.size() - 1)];
      else if (sel <= 7 && known_types.size() != 0)
         key.res_type = known_types[$urandom_range(0, known_types.size() - 1)];
      else if (sel == 9) begin
         key.res_type = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         case ($urandom_range(0, 3))
            0: key.res_id = 16'h8000;
            1: key.res_id = 16'h7FFF;
            2: key.res_id = 16'h0000;
            default: key.res_id = 16'hFFFF;
         endcase
      end
      return key;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------------------

   // Present one item and hold it until the request transfer. Valid stays high on return so
   // that a following item goes out back to back.
   task automatic push_item(request_item_type it);
      if (idling && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.action       <= it.action;
      req_ch.load_address <= it.load_address;
      req_ch.load_byte    <= it.load_byte;
      req_ch.res_type     <= it.res_type;
      req_ch.res_id       <= it.res_id;
      @(posedge clock);
      while (req_ch.ready !== 1'b1)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic send_load(logic [MEM_AW-1:0] addr, logic [7:0] value);
      request_item_type it;
      it.action       = ACT_LOAD;
      it.load_address = addr;
      it.load_byte    = value;
      it.res_type     = $urandom();   // don't-care fields, randomised anyway
      it.res_id       = 16'($urandom());
      push_item(it);
      image_copy[addr] = value;
      loaded[addr]     = 1'b1;
   endtask

   // Load whatever the walk still lacks, one byte at a time, then send the lookup itself.
   task automatic run_lookup(logic [31:0] want_type, logic [15:0] want_id);
      lookup_answer_type ans;
      request_item_type  it;
      logic [MEM_AW-1:0] gap;
      while (1) begin
         ans = walk_resource_map(want_type, want_id);
         if (first_gap < 0)
            break;
         gap = MEM_AW'(first_gap);
         send_load(gap, plan_set[gap] ? plan_val[gap] : 8'hFF);
      end
      it.action       = ACT_LOOKUP;
      it.load_address = MEM_AW'($urandom());
      it.load_byte    = 8'($urandom());
      it.res_type     = want_type;
      it.res_id       = want_id;
      push_item(it);
      ledger.note_lookup(ans);
   endtask

   // Drop valid and wait for every answer, then give a trailing load time to land.
   task automatic drain_block();
      req_ch.valid <= 1'b0;
      while (ledger.outstanding() != 0)
         @(posedge clock);
      repeat (LOAD_SETTLE) @(posedge clock);
   endtask

   task automatic write_image_size(logic [SIZE_W-1:0] value);
      drain_block();
      csr_wr.valid      <= 1'b1;
      csr_wr.image_size <= value;
      @(posedge clock);
      while (csr_wr.ready !== 1'b1)
         @(posedge clock);
      csr_wr.valid <= 1'b0;
      size_copy = value;
   endtask

   // ---------------------------------------------------------------------------------------
   // Response side: random back-pressure bursts, checking of every response transfer
   // ---------------------------------------------------------------------------------------

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (idling && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         ledger.check_answer(rsp_ch.status, rsp_ch.data_address, rsp_ch.data_length);
   end

   // Watchdog: end the run if no channel moves a transfer for too long.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_wr.valid && csr_wr.ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------

   initial begin
      logic [SIZE_W-1:0] next_size;
      int unsigned       n_lookups, n_noise, mode;
      bit                big, short_phase;
      logic [MEM_AW-1:0] noise_addr;
      resource_key_type  key;

      ledger = new();
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.action       <= ACT_LOAD;
      req_ch.load_address <= '0;
      req_ch.load_byte    <= '0;
      req_ch.res_type     <= '0;
      req_ch.res_id       <= '0;
      csr_wr.valid        <= 1'b0;
      csr_wr.image_size   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // --- Directed part ---
      // no image at all
      write_image_size('0);
      run_lookup($urandom(), 16'($urandom()));

      // image with a shadowed duplicate type and extreme offsets where they fit
      plan_image(3, 1, 3, 1'b1, 1'b1, 1'b0);
      write_image_size(SIZE_W'(HEADER_BYTES - 1));                 // too short for a header
      run_lookup(known_types[0], known_keys[0].res_id);
      write_image_size(SIZE_W'(HEADER_BYTES));                     // header fits, map cannot
      run_lookup(known_types[0], known_keys[0].res_id);
      write_image_size(SIZE_W'(plan_map_off + MAP_MIN_BYTES - 1)); // map one byte past the end
      run_lookup(known_types[0], known_keys[0].res_id);
      write_image_size(SIZE_W'(plan_map_off + MAP_MIN_BYTES));     // map just fits
      foreach (known_keys[k])
         run_lookup(known_keys[k].res_type, known_keys[k].res_id);
      run_lookup(32'h0, 16'h8000);
      run_lookup(32'hFFFF_FFFF, 16'h7FFF);
      run_lookup(known_types[2], 16'h8000);

      // empty type list, map at the top of an oversized image so its reads wrap
      plan_image(0, 0, 0, 1'b0, 1'b0, 1'b1);
      write_image_size(SIZE_MAX);
      run_lookup($urandom(), 16'($urandom()));

      // types whose reference lists are empty
      plan_image(2, 0, 0, 1'b0, 1'b0, 1'b0);
      write_image_size(SIZE_W'($urandom_range(plan_map_off + MAP_MIN_BYTES, SIZE_MAX)));
      run_lookup(known_types[0], 16'($urandom()));
      run_lookup(known_types[1], 16'($urandom()));

      // --- Random part: one image per phase, a burst of lookups against it ---
      while (items_sent < ITEM_GOAL) begin
         // quiet handshakes now and then, and throughout the closing stretch
         idling = (items_sent < ITEM_GOAL * 85 / 100) && ($urandom_range(0, 4) != 0);
         big    = ($urandom_range(0, 9) == 0);
         plan_image(big ? 12 : $urandom_range(1, 5), 0, big ? 10 : $urandom_range(1, 4),
                    $urandom_range(0, 5) == 0, $urandom_range(0, 7) == 0, 1'b0);

         mode = $urandom_range(0, 9);
         case (mode)
            0: next_size = SIZE_W'($urandom_range(0, HEADER_BYTES - 1));
            1: next_size = SIZE_W'($urandom_range(HEADER_BYTES,
                                                  plan_map_off + MAP_MIN_BYTES - 1));
            2: next_size = SIZE_MAX;
            3: next_size = SIZE_W'(plan_map_off + MAP_MIN_BYTES);
            default: next_size = SIZE_W'($urandom_range(plan_map_off + MAP_MIN_BYTES,
                                                        SIZE_MAX));
         endcase
         short_phase = (mode <= 1);
         write_image_size(next_size);

         n_lookups = short_phase ? 3 : $urandom_range(12, 30);
         repeat (n_lookups) begin
            // stop as soon as the item budget is spent
            if (items_sent >= ITEM_GOAL)
               break;
            // stray loads into bytes that no lookup of this image reads
            if ($urandom_range(0, 5) == 0) begin
               n_noise = $urandom_range(1, 3);
               repeat (n_noise) begin
                  do noise_addr = MEM_AW'($urandom()); while (plan_set[noise_addr]);
                  send_load(noise_addr, 8'($urandom()));
               end
            end
            key = choose_key();
            run_lookup(key.res_type, key.res_id);
         end
      end

      // --- Wind down ---
      drain_block();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.errors == 0 && ledger.outstanding() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
